@@ src/ultrasonic_range_averager_core_assert.svh @@
// assertion macros used by the range averager port checker
`ifndef ULTRASONIC_RANGE_AVERAGER_CORE_ASSERT_SVH
`define ULTRASONIC_RANGE_AVERAGER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define URA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ura assertion failed");

// next-cycle implication, disabled while in reset
`define URA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ura assertion failed");

`endif

@@ src/ura_pkg.sv @@
// types, constants and field layout of the ultrasonic range averager
package ura_pkg;

    // stream field layout
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int S_ECHO_BIT = 0;
    localparam int S_START_BIT = 1;
    localparam int M_TRIG_BIT = 0;
    localparam int M_DONE_BIT = 1;
    localparam int M_DIST_LSB = 2;

    // field and state widths
    localparam int TIMER_W = 16;
    localparam int WIDTH_W = 16;
    localparam int SCALE_W = 16;
    localparam int DIST_W = 8;
    localparam int SUM_W = 10;
    localparam int COUNT_W = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ECHO_TIMEOUT = 3'd0,
        CFG_CM_PER_US = 3'd1,
        CFG_MAX_DIST = 3'd2,
        CFG_MIN_VALID = 3'd3,
        CFG_SETTLE = 3'd4
    } cfg_index_t;

    // register defaults
    localparam logic [TIMER_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [SCALE_W-1:0] CM_PER_US_RST = 16'd1124;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 8'd100;
    localparam logic [DIST_W-1:0] MIN_VALID_RST = 8'd10;
    localparam logic [TIMER_W-1:0] SETTLE_RST = 16'd50000;

    // sequence constants
    localparam logic [TIMER_W-1:0] TRIG_LOW_TICKS = 16'd5;
    localparam logic [TIMER_W-1:0] TRIG_HIGH_TICKS = 16'd10;
    localparam logic [COUNT_W-1:0] READINGS_NEEDED = 2'd3;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;

    // sum / 3 as multiply by reciprocal, exact for sums below 1536
    localparam int DIV3_MULT_W = 10;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = 10'd683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PROD_W = SUM_W + DIV3_MULT_W;

    // measurement sequencer
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_TRIG_LOW = 6'b000010,
        PH_TRIG_HIGH = 6'b000100,
        PH_WAIT = 6'b001000,
        PH_MEASURE = 6'b010000,
        PH_SETTLE = 6'b100000
    } phase_t;

endpackage

@@ src/ultrasonic_range_averager_core.sv @@
// ultrasonic range averager: one microsecond tick in, one pin/result word out
// result: registered, and appears in the cycle after its tick is transferred
// throughput: one tick per cycle unless stalled, set by the single state/result register
// backpressure: a new tick is taken whenever the result register is empty or drains
// reset: synchronous active-low aresetn puts the sequencer in idle, clears the
// timers, sum and count, empties the result register and restores register defaults
module ultrasonic_range_averager_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input ticks
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ura_pkg::S_TDATA_W-1:0]    s_tdata,    // [0] echo_level, [1] start_req
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ura_pkg::M_TDATA_W-1:0]    m_tdata,    // [0] trigger_level, [1] done_res,
                                                         // [9:2] distance_cm
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ura_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ura_pkg::*;

    // configuration registers
    logic [TIMER_W-1:0] echo_timeout_reg;
    logic [SCALE_W-1:0] cm_per_us_reg;
    logic [DIST_W-1:0]  max_dist_reg;
    logic [DIST_W-1:0]  min_valid_reg;
    logic [TIMER_W-1:0] settle_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // result register
    logic               m_valid_reg;
    logic               trig_reg, trig_next;
    logic               done_reg, done_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;

    // datapath
    logic                          echo;
    logic                          start;
    logic                          accept;
    logic [TIMER_W-1:0]            timer_inc;
    logic [TIMER_W-1:0]            timer_sat;
    logic [SCALE_W+WIDTH_W-1:0]    scale_prod;
    logic [WIDTH_W-1:0]            cm_raw;
    logic [DIST_W-1:0]             reading;
    logic [DIV3_PROD_W-1:0]        div3_prod;
    logic                          finish;
    logic [DIST_W-1:0]             finish_reading;

    assign echo   = s_tdata[S_ECHO_BIT];
    assign start  = s_tdata[S_START_BIT];
    assign accept = s_tvalid && s_tready;

    // result register frees up when empty or draining
    assign s_tready  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - DIST_W - 2){1'b0}}, dist_reg, done_reg, trig_reg};
    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_timeout_reg <= ECHO_TIMEOUT_RST;
            cm_per_us_reg    <= CM_PER_US_RST;
            max_dist_reg     <= MAX_DIST_RST;
            min_valid_reg    <= MIN_VALID_RST;
            settle_reg       <= SETTLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ECHO_TIMEOUT: echo_timeout_reg <= cfg_data;
                CFG_CM_PER_US:    cm_per_us_reg    <= cfg_data;
                CFG_MAX_DIST:     max_dist_reg     <= cfg_data[DIST_W-1:0];
                CFG_MIN_VALID:    min_valid_reg    <= cfg_data[DIST_W-1:0];
                CFG_SETTLE:       settle_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // timer increments
    assign timer_inc = timer_reg + TIMER_W'(1);
    assign timer_sat = (timer_reg == TIMER_MAX) ? timer_reg : timer_inc;

    // echo width to centimetres, truncated and clamped
    assign scale_prod = width_reg * cm_per_us_reg;
    assign cm_raw     = scale_prod[SCALE_W+WIDTH_W-1:SCALE_W];
    assign reading    = (cm_raw > {{(WIDTH_W-DIST_W){1'b0}}, max_dist_reg}) ?
                        max_dist_reg : cm_raw[DIST_W-1:0];

    // average of the three readings
    assign div3_prod = sum_reg * DIV3_MULT;

    // sequencer next state and result
    always_comb begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        width_next     = width_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        trig_next      = 1'b0;
        done_next      = 1'b0;
        dist_next      = '0;
        finish         = 1'b0;
        finish_reading = '0;

        unique case (phase_reg)
            PH_TRIG_LOW: begin
                timer_next = timer_inc;
                if (timer_inc >= TRIG_LOW_TICKS) begin
                    phase_next = PH_TRIG_HIGH;
                    timer_next = '0;
                end
            end
            PH_TRIG_HIGH: begin
                trig_next  = 1'b1;
                timer_next = timer_inc;
                if (timer_inc >= TRIG_HIGH_TICKS) begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    phase_next = PH_MEASURE;
                    width_next = WIDTH_W'(1);
                end else begin
                    timer_next = timer_sat;
                    // timeout yields a zero reading
                    if (timer_sat >= echo_timeout_reg) begin
                        finish = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (width_reg != WIDTH_MAX) begin
                        width_next = width_reg + WIDTH_W'(1);
                    end
                end else begin
                    finish         = 1'b1;
                    finish_reading = reading;
                end
            end
            PH_SETTLE: begin
                timer_next = timer_sat;
                if (timer_sat >= settle_reg) begin
                    timer_next = '0;
                    if (count_reg >= READINGS_NEEDED) begin
                        done_next  = 1'b1;
                        dist_next  = div3_prod[DIV3_SHIFT+DIST_W-1:DIV3_SHIFT];
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_TRIG_LOW;
                    end
                end
            end
            default: begin
                // idle and any stray code
                phase_next = PH_IDLE;
                if (start) begin
                    sum_next   = '0;
                    count_next = '0;
                    width_next = '0;
                    timer_next = '0;
                    phase_next = PH_TRIG_LOW;
                end
            end
        endcase

        // end of an attempt: keep good readings, then settle
        if (finish) begin
            if (finish_reading > min_valid_reg && count_reg < READINGS_NEEDED) begin
                sum_next   = sum_reg + {{(SUM_W-DIST_W){1'b0}}, finish_reading};
                count_next = count_reg + COUNT_W'(1);
            end
            phase_next = PH_SETTLE;
            timer_next = '0;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            width_reg   <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                width_reg <= width_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            trig_reg <= trig_next;
            done_reg <= done_next;
            dist_reg <= dist_next;
        end
    end

endmodule

@@ src/ura_checker.sv @@
// port-level checks for the ultrasonic range averager
`include "ultrasonic_range_averager_core_assert.svh"

module ura_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ura_pkg::M_TDATA_W-1:0]    m_tdata     // [0] trigger_level, [1] done_res,
                                                         // [9:2] distance_cm
);
    import ura_pkg::*;

    logic done_out;
    logic trig_out;
    logic [DIST_W-1:0] dist_out;

    assign done_out = m_tdata[M_DONE_BIT];
    assign trig_out = m_tdata[M_TRIG_BIT];
    assign dist_out = m_tdata[M_DIST_LSB+DIST_W-1:M_DIST_LSB];

    // a stalled result holds
    `URA_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // every transferred tick gives a result in the next cycle
    `URA_ASSERT_NEXT(a_tick_gives_result, aclk, aresetn, s_tvalid && s_tready, m_tvalid)

    // an empty result register never blocks the input
    `URA_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // the average is only reported outside the trigger pulse
    `URA_ASSERT_SAME(a_done_no_trigger, aclk, aresetn, m_tvalid && done_out, !trig_out)

    // distance is zero except with done
    `URA_ASSERT_SAME(a_dist_only_done, aclk, aresetn, m_tvalid && !done_out,
        dist_out == '0)

endmodule

bind ultrasonic_range_averager_core ura_checker u_ura_checker (.*);

@@ sim/ura_range_checker.sv @@
// range averager checker: mirrors registers and sequencer, checks each result transfer
module ura_range_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ura_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ura_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ura_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               error_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ura_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // one result word, split into its fields
    typedef struct packed {
        logic              trig;
        logic              done;
        logic [DIST_W-1:0] dist_cm;
    } pin_word_t;

    // register copies
    logic [TIMER_W-1:0] timeout_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DIST_W-1:0]  max_reg;
    logic [DIST_W-1:0]  min_reg;
    logic [TIMER_W-1:0] settle_reg;

    // sequencer copy
    phase_t             phase;
    logic [TIMER_W-1:0] phase_timer;
    logic [WIDTH_W-1:0] echo_width;
    logic [SUM_W-1:0]   reading_sum;
    logic [COUNT_W-1:0] accepted;

    pin_word_t pending_words[$];
    int        bad;
    int        results_seen;

    // echo width to centimetres, truncated and clamped
    function automatic logic [DIST_W-1:0] width_to_cm(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W+SCALE_W-1:0] prod;
        logic [WIDTH_W-1:0]         whole;
        prod = 32'(w) * 32'(scale_reg);
        whole = prod[WIDTH_W+SCALE_W-1:SCALE_W];
        if (whole > WIDTH_W'(max_reg)) begin
            return max_reg;
        end
        return whole[DIST_W-1:0];
    endfunction

    // keep a reading above the floor, then go settle
    task automatic close_attempt(input logic [DIST_W-1:0] cm);
        if (cm > min_reg && accepted < READINGS_NEEDED) begin
            reading_sum = reading_sum + SUM_W'(cm);
            accepted = accepted + 2'd1;
        end
        phase = PH_SETTLE;
        phase_timer = '0;
    endtask

    // one microsecond tick of the sequencer
    task automatic advance_ranging(input logic echo, input logic start, output pin_word_t word);
        logic [SUM_W-1:0] quotient;
        word = '0;
        case (phase)
            PH_TRIG_LOW: begin
                phase_timer = phase_timer + 16'd1;
                if (phase_timer >= TRIG_LOW_TICKS) begin
                    phase = PH_TRIG_HIGH;
                    phase_timer = '0;
                end
            end
            PH_TRIG_HIGH: begin
                word.trig = 1'b1;
                phase_timer = phase_timer + 16'd1;
                if (phase_timer >= TRIG_HIGH_TICKS) begin
                    phase = PH_WAIT;
                    phase_timer = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    phase = PH_MEASURE;
                    echo_width = 16'd1;
                end else begin
                    if (phase_timer != TIMER_MAX) begin
                        phase_timer = phase_timer + 16'd1;
                    end
                    if (phase_timer >= timeout_reg) begin
                        close_attempt('0);
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (echo_width != WIDTH_MAX) begin
                        echo_width = echo_width + 16'd1;
                    end
                end else begin
                    close_attempt(width_to_cm(echo_width));
                end
            end
            PH_SETTLE: begin
                if (phase_timer != TIMER_MAX) begin
                    phase_timer = phase_timer + 16'd1;
                end
                if (phase_timer >= settle_reg) begin
                    phase_timer = '0;
                    if (accepted >= READINGS_NEEDED) begin
                        quotient = reading_sum / SUM_W'(READINGS_NEEDED);
                        word.done = 1'b1;
                        word.dist_cm = quotient[DIST_W-1:0];
                        phase = PH_IDLE;
                    end else begin
                        phase = PH_TRIG_LOW;
                    end
                end
            end
            default: begin
                phase = PH_IDLE;
                if (start) begin
                    reading_sum = '0;
                    accepted = '0;
                    echo_width = '0;
                    phase_timer = '0;
                    phase = PH_TRIG_LOW;
                end
            end
        endcase
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        pin_word_t want;
        pin_word_t got;
        if (!aresetn) begin
            timeout_reg = ECHO_TIMEOUT_RST;
            scale_reg = CM_PER_US_RST;
            max_reg = MAX_DIST_RST;
            min_reg = MIN_VALID_RST;
            settle_reg = SETTLE_RST;
            phase = PH_IDLE;
            phase_timer = '0;
            echo_width = '0;
            reading_sum = '0;
            accepted = '0;
            pending_words.delete();
            bad = 0;
            results_seen = 0;
        end else begin
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ECHO_TIMEOUT: timeout_reg = cfg_data;
                    CFG_CM_PER_US:    scale_reg = cfg_data;
                    CFG_MAX_DIST:     max_reg = cfg_data[DIST_W-1:0];
                    CFG_MIN_VALID:    min_reg = cfg_data[DIST_W-1:0];
                    CFG_SETTLE:       settle_reg = cfg_data;
                    default: ;
                endcase
            end
            // result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.trig = m_tdata[M_TRIG_BIT];
                got.done = m_tdata[M_DONE_BIT];
                got.dist_cm = m_tdata[M_DIST_LSB +: DIST_W];
                if (pending_words.size() == 0) begin
                    if (bad < REPORT_LIMIT) begin
                        $display("result %0d with nothing predicted: trig %0b done %0b dist %0d",
                                 results_seen, got.trig, got.done, got.dist_cm);
                    end
                    bad++;
                end else begin
                    want = pending_words.pop_front();
                    if (got.trig !== want.trig || got.done !== want.done
                            || got.dist_cm !== want.dist_cm) begin
                        if (bad < REPORT_LIMIT) begin
                            $display("result %0d exp trig/done/dist %0b %0b %0d, got %0b %0b %0d",
                                     results_seen, want.trig, want.done, want.dist_cm,
                                     got.trig, got.done, got.dist_cm);
                        end
                        bad++;
                    end
                end
                results_seen++;
            end
            // tick transfer
            if (s_tvalid && s_tready) begin
                advance_ranging(s_tdata[S_ECHO_BIT], s_tdata[S_START_BIT], want);
                pending_words.push_back(want);
            end
        end
        outstanding <= pending_words.size();
        error_count <= bad;
    end

endmodule

@@ sim/tb_ultrasonic_range_averager_core.sv @@
// range averager testbench top: clock, reset, tick and register stimulus, verdict
module tb_ultrasonic_range_averager_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ura_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_TAIL = 2;
    localparam int TRIG_TICKS = int'(TRIG_LOW_TICKS) + int'(TRIG_HIGH_TICKS);
    localparam int Q16_ONE = 65536;
    localparam int WIDTH_TOP = int'(WIDTH_MAX);
    localparam int TARGET_WIDTH_CAP = 200;
    localparam int TIMEOUT_RUN_CAP = 400;
    localparam int CLAMP_ECHO_TICKS = 270;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int error_count;
    int outstanding;

    // idling knobs and the receiver hold-off handshake
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int tick_count = 0;

    // register values last written, used to shape pulses
    int cfg_timeout;
    int cfg_scale;
    int cfg_max;
    int cfg_min;
    int cfg_settle;

    // where the current averaging run stands
    bit run_active = 1'b0;
    int run_readings = 0;

    ultrasonic_range_averager_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ura_range_checker u_range_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[ultrasonic_range_averager_core] ERROR");
        $finish;
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // one tick transfer, with random idle cycles in front
    task automatic send_tick(input logic echo, input logic start);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_ECHO_BIT] = echo;
        word[S_START_BIT] = start;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        tick_count++;
    endtask

    // ticks whose echo and start the block ignores
    task automatic send_filler(input int n);
        repeat (n) send_tick(coin(), coin());
    endtask

    // stop sending and wait for every predicted result
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_one(input cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input int timeout_v, input int scale_v, input int max_v,
                                  input int min_v, input int settle_v);
        write_one(CFG_ECHO_TIMEOUT, timeout_v);
        write_one(CFG_CM_PER_US, scale_v);
        write_one(CFG_MAX_DIST, max_v);
        write_one(CFG_MIN_VALID, min_v);
        write_one(CFG_SETTLE, settle_v);
        cfg_valid <= 1'b0;
        cfg_timeout = timeout_v;
        cfg_scale = scale_v;
        cfg_max = max_v;
        cfg_min = min_v;
        cfg_settle = settle_v;
    endtask

    task automatic begin_run();
        send_tick(coin(), 1'b1);
        run_active = 1'b1;
        run_readings = 0;
    endtask

    // trigger, low wait ticks, echo pulse of the given width, settle
    task automatic pulse_attempt(input int delay, input int width);
        longint prod;
        int     cm;
        send_filler(TRIG_TICKS);
        repeat (delay) send_tick(1'b0, coin());
        repeat (width) send_tick(1'b1, coin());
        send_tick(1'b0, coin());
        prod = longint'((width > WIDTH_TOP) ? WIDTH_TOP : width) * cfg_scale;
        cm = int'(prod >> 16);
        if (cm > cfg_max) begin
            cm = cfg_max;
        end
        if (cm > cfg_min) begin
            run_readings++;
        end
        send_filler((cfg_settle == 0) ? 1 : cfg_settle);
        if (run_readings >= int'(READINGS_NEEDED)) begin
            run_active = 1'b0;
        end
    endtask

    // trigger, echo never rises, settle
    task automatic timeout_attempt();
        send_filler(TRIG_TICKS);
        repeat ((cfg_timeout == 0) ? 1 : cfg_timeout) send_tick(1'b0, coin());
        send_filler((cfg_settle == 0) ? 1 : cfg_settle);
    endtask

    // mostly pulses wide enough to be kept, some short ones and some timeouts
    task automatic ranging_attempt();
        int wait_limit;
        int w_need;
        int w;
        int d;
        int roll;
        wait_limit = (cfg_timeout == 0) ? 1 : cfg_timeout;
        roll = $urandom_range(99);
        w_need = 0;
        if (cfg_scale != 0 && cfg_max > cfg_min) begin
            w_need = ((cfg_min + 1) * Q16_ONE + cfg_scale - 1) / cfg_scale;
        end
        if (roll < 8 && wait_limit <= TIMEOUT_RUN_CAP) begin
            timeout_attempt();
        end else begin
            d = $urandom_range((wait_limit - 1 < 30) ? wait_limit - 1 : 30);
            if (roll < 30 || w_need == 0 || w_need > TARGET_WIDTH_CAP) begin
                w = $urandom_range(40, 1);
            end else begin
                w = w_need + $urandom_range(6);
            end
            pulse_attempt(d, w);
        end
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        stop_at = tick_count + n_items;
        while (tick_count < stop_at) begin
            if (run_active) begin
                ranging_attempt();
            end else if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(6, 1)) send_tick(coin(), 1'b0);
            end else begin
                begin_run();
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ECHO_TIMEOUT;
        cfg_data = '0;
        cfg_timeout = int'(ECHO_TIMEOUT_RST);
        cfg_scale = int'(CM_PER_US_RST);
        cfg_max = int'(MAX_DIST_RST);
        cfg_min = int'(MIN_VALID_RST);
        cfg_settle = int'(SETTLE_RST);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // echo while idle is ignored
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        // long settle and timeout cut short by writes during a run
        quiesce();
        apply_settings(65535, 1124, 100, 10, 65535);
        begin_run();
        send_filler(TRIG_TICKS);
        repeat (5) send_tick(1'b0, coin());
        repeat (10) send_tick(1'b1, coin());
        send_tick(1'b0, coin());
        send_filler(20);
        quiesce();
        apply_settings(65535, 1124, 100, 10, 2);
        send_filler(1);
        send_filler(TRIG_TICKS);
        repeat (10) send_tick(1'b0, 1'b1);
        quiesce();
        apply_settings(5, 1124, 100, 10, 2);
        send_tick(1'b0, 1'b0);
        send_filler(2);

        // zero timeout and settle, full scale, echo wide enough to clamp
        quiesce();
        apply_settings(0, 65535, 255, 0, 0);
        timeout_attempt();
        pulse_attempt(0, 2);
        pulse_attempt(0, CLAMP_ECHO_TICKS);
        pulse_attempt(0, 1);
        pulse_attempt(0, 3);
        send_tick(1'b1, 1'b0);

        // no idling, then a long receiver hold-off while ticks keep coming
        quiesce();
        apply_settings(20, 40000, 200, 5, 3);
        random_phase(200);
        hold_req = hold_req + 1;
        random_phase(100);

        // extremes that keep every reading out
        quiesce();
        apply_settings(70, 0, 0, 255, 4);
        random_phase(100);

        // sender mostly idle
        quiesce();
        src_idle_pct = 81;
        apply_settings(1, 65535, 255, 0, 0);
        random_phase(300);

        // receiver mostly stalled
        quiesce();
        src_idle_pct = 0;
        sink_stall_pct = 81;
        apply_settings(300, 30000, 60, 30, 10);
        random_phase(300);

        // light idling on both sides, with a full pause midway
        quiesce();
        src_idle_pct = 9;
        sink_stall_pct = 9;
        apply_settings(8, 50000, 150, 20, 1);
        random_phase(150);
        quiesce();
        random_phase(150);

        quiesce();
        if (error_count == 0 && outstanding == 0) begin
            $display("[ultrasonic_range_averager_core] OK");
        end else begin
            $display("[ultrasonic_range_averager_core] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ura_pkg.sv
src/ultrasonic_range_averager_core.sv
src/ura_checker.sv
sim/ura_range_checker.sv
sim/tb_ultrasonic_range_averager_core.sv
